// ===== sv/huffman_tree_byte_decoder_assert.svh =====
// assertion macros used by the decoder walker module
`ifndef HUFFMAN_TREE_BYTE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_BYTE_DECODER_ASSERT_SVH

// same-cycle implication
`define HUFD_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HUFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hufd_pkg.sv =====
`timescale 1ns / 1ps

package hufd_pkg;

  localparam int NODE_COUNT_DEF = 255;
  localparam int COUNT_BITS_DEF = 24;

  localparam int NODE_W    = 8;
  localparam int CHILD_W   = 9;
  localparam int SYM_W     = 8;
  localparam int LEN_W     = 24;
  localparam int BYTE_BITS = 8;
  localparam int BIT_CNT_W = 3;
  localparam int IN_DATA_W = 40;

  localparam logic CMD_WRITE_NODE  = 1'b0;
  localparam logic CMD_DECODE_BYTE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [CHILD_W-1:0] one_child;
    logic [CHILD_W-1:0] zero_child;
  } node_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } emit_t;

endpackage

// ===== sv/hufd_node_ram.sv =====
`timescale 1ns / 1ps

module hufd_node_ram #(
  parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [hufd_pkg::NODE_W-1:0] wr_addr,
  input  hufd_pkg::node_t             wr_data,
  input  logic [hufd_pkg::NODE_W-1:0] rd_addr,
  output hufd_pkg::node_t             rd_data
);

  localparam int NW = hufd_pkg::NODE_W;
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [NW-1:0] LIMIT = NW'(NODE_COUNT);

  hufd_pkg::node_t mem [NODE_COUNT];
  hufd_pkg::node_t rd_data_r;
  logic            oob_r;
  logic            wr_ok;
  logic            rd_ok;

  assign wr_ok = wr_en && (wr_addr < LIMIT);
  assign rd_ok = rd_addr < LIMIT;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  // write-through so the walk sees a node written in the same cycle
  always_ff @(posedge clk) begin
    if (wr_ok && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oob_r <= 1'b0;
    end else begin
      oob_r <= !rd_ok;
    end
  end

  // nodes past the table read as two zero leaves
  assign rd_data = oob_r ? '0 : rd_data_r;

endmodule

// ===== sv/hufd_walker.sv =====
`timescale 1ns / 1ps

module hufd_walker #(
  parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF,
  parameter int COUNT_BITS = hufd_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_cmd,
  input  logic [hufd_pkg::SYM_W-1:0]  in_source,
  output logic                        in_ready,
  input  logic [hufd_pkg::LEN_W-1:0]  expanded_length,
  input  hufd_pkg::node_t             rd_node,
  output logic [hufd_pkg::NODE_W-1:0] rd_addr,
  input  logic                        out_free,
  output hufd_pkg::emit_t             emit
);

  `include "huffman_tree_byte_decoder_assert.svh"

  localparam int NW    = hufd_pkg::NODE_W;
  localparam int BW    = hufd_pkg::BIT_CNT_W;
  localparam int CMP_W = (COUNT_BITS > hufd_pkg::LEN_W) ? COUNT_BITS : hufd_pkg::LEN_W;
  localparam logic [NW-1:0] HEAD_NODE = NW'(NODE_COUNT - 1);
  localparam logic [BW-1:0] LAST_BIT  = BW'(hufd_pkg::BYTE_BITS - 1);

  hufd_pkg::state_t                state_r, state_nxt;
  logic [NW-1:0]                   cur_r, cur_nxt;
  logic [COUNT_BITS-1:0]           cnt_r, cnt_nxt;
  logic [hufd_pkg::SYM_W-1:0]      sr_r, sr_nxt;
  logic [BW-1:0]                   bit_r, bit_nxt;

  logic [hufd_pkg::CHILD_W-1:0]    child;
  logic                            leaf;
  logic [COUNT_BITS-1:0]           next_cnt;
  logic                            last;
  logic                            run;
  logic                            adv;
  logic                            finish;
  logic                            accept;
  logic                            start;

  assign child    = sr_r[0] ? rd_node.one_child : rd_node.zero_child;
  assign leaf     = !child[hufd_pkg::CHILD_W-1];
  assign next_cnt = cnt_r + COUNT_BITS'(1);
  assign last     = (next_cnt == '0) || (CMP_W'(next_cnt) >= CMP_W'(expanded_length));
  assign run      = (state_r == hufd_pkg::ST_RUN);
  assign accept   = in_valid && in_ready;
  assign start    = accept && (in_cmd == hufd_pkg::CMD_DECODE_BYTE);

  // outputs
  always_comb begin
    adv          = run && (!leaf || out_free);
    finish       = adv && ((bit_r == LAST_BIT) || (leaf && last));
    in_ready     = !run || finish;
    emit.valid   = adv && leaf;
    emit.symbol  = child[hufd_pkg::SYM_W-1:0];
    emit.last    = last;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hufd_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = hufd_pkg::ST_RUN;
        end
      end
      hufd_pkg::ST_RUN: begin
        if (finish) begin
          state_nxt = start ? hufd_pkg::ST_RUN : hufd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hufd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    sr_nxt  = sr_r;
    bit_nxt = bit_r;
    if (adv) begin
      cur_nxt = leaf ? HEAD_NODE : child[NW-1:0];
      sr_nxt  = sr_r >> 1;
      bit_nxt = bit_r + BW'(1);
      if (leaf) begin
        cnt_nxt = last ? '0 : next_cnt;
      end
    end
    if (finish) begin
      bit_nxt = '0;
    end
    if (start) begin
      sr_nxt  = in_source;
      bit_nxt = '0;
    end
  end

  // table read follows the node that the walk will hold next
  assign rd_addr = cur_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hufd_pkg::ST_IDLE;
      cur_r   <= HEAD_NODE;
      cnt_r   <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

  `HUFD_ASSERT_HOLDS(a_emit_in_run, clk, rst_n, emit.valid, run, "symbol emitted outside a walk")
  `HUFD_ASSERT_NEXT(a_stall_hold, clk, rst_n, run && leaf && !out_free, $stable(cur_r) && $stable(bit_r), "walk moved while output stalled")
  `HUFD_ASSERT_NEXT(a_last_clears, clk, rst_n, emit.valid && last, cnt_r == '0, "count not cleared after last symbol")
  `HUFD_ASSERT_HOLDS(a_idle_bit, clk, rst_n, state_r == hufd_pkg::ST_IDLE, bit_r == '0, "bit counter not cleared in idle")

endmodule

// ===== sv/huffman_tree_byte_decoder.sv =====
`timescale 1ns / 1ps
// Huffman tree byte decoder, least significant bit first.
// in_ channel: one transfer is either a tree node write (in_tuser = 0, node_index with
// its two children) or a source byte to decode (in_tuser = 1). Node writes give no
// result; a write to an index past the table is dropped.
// out_ channel: one transfer per decoded symbol, out_tlast marks the symbol that
// completes expanded_length, after which the rest of that byte is dropped.
// cfg_: expanded_length, to be written only while the block is idle; the block does not enforce this.
// A source byte is walked with one tree lookup per bit; the node table
// read port is in the loop, the next address coming from the registered read data.
// A new item is taken in the cycle that the last bit of a byte, or the symbol that
// completes expanded_length, is walked. A symbol shows on out_ in the cycle after
// the bit that reaches its leaf, through the output register.
// A stalled receiver holds the walk on the bit that found a leaf until the output
// register frees up; bits that reach an inner node still advance.
// Reset: the walk returns to the head node, the symbol count clears and
// expanded_length is 1; table contents are undefined until written.

module huffman_tree_byte_decoder #(
  parameter int NODE_COUNT = hufd_pkg::NODE_COUNT_DEF,
  parameter int COUNT_BITS = hufd_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // node_index[7:0], zero_child[16:8], one_child[25:17], source_byte[33:26], zero pad
  input  logic [hufd_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // symbol[7:0]
  output logic [hufd_pkg::SYM_W-1:0]        out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [hufd_pkg::LEN_W-1:0]        cfg_wr_data
);

  logic [hufd_pkg::LEN_W-1:0]  len_r;
  logic                        out_valid_r;
  logic [hufd_pkg::SYM_W-1:0]  sym_r;
  logic                        last_r;
  logic                        out_free;
  logic                        node_we;
  hufd_pkg::node_t             wr_node;
  hufd_pkg::node_t             rd_node;
  logic [hufd_pkg::NODE_W-1:0] rd_addr;
  hufd_pkg::emit_t             emit;

  assign wr_node.zero_child = in_tdata[16:8];
  assign wr_node.one_child  = in_tdata[25:17];
  assign node_we = in_tvalid && in_tready && (in_tuser == hufd_pkg::CMD_WRITE_NODE);
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= hufd_pkg::LEN_W'(1);
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  hufd_node_ram #(
    .NODE_COUNT (NODE_COUNT)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (node_we),
    .wr_addr (in_tdata[7:0]),
    .wr_data (wr_node),
    .rd_addr (rd_addr),
    .rd_data (rd_node)
  );

  hufd_walker #(
    .NODE_COUNT (NODE_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_walker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_cmd          (in_tuser),
    .in_source       (in_tdata[33:26]),
    .in_ready        (in_tready),
    .expanded_length (len_r),
    .rd_node         (rd_node),
    .rd_addr         (rd_addr),
    .out_free        (out_free),
    .emit            (emit)
  );

  // output register parts the walk from the receiver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      sym_r  <= emit.symbol;
      last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = sym_r;
  assign out_tlast  = last_r;

endmodule

// ===== dv/huffman_tree_byte_decoder_test.sv =====
`timescale 1ns / 1ps

module huffman_tree_byte_decoder_test;

  localparam logic [hufd_pkg::NODE_W-1:0] HEAD_NODE =
    hufd_pkg::NODE_W'(hufd_pkg::NODE_COUNT_DEF - 1);
  localparam logic [hufd_pkg::NODE_W-1:0] NO_NODE =
    hufd_pkg::NODE_W'(hufd_pkg::NODE_COUNT_DEF);
  localparam int LEAF_LIMIT = 256;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 60;
  localparam logic [hufd_pkg::LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    ROW_NODE,
    ROW_BYTE,
    ROW_LEN
  } row_kind_t;

  typedef struct packed {
    logic [hufd_pkg::SYM_W-1:0] symbol;
    logic                       chunk_last;
  } sym_result_t;

  typedef struct {
    row_kind_t                    kind;
    logic [hufd_pkg::NODE_W-1:0]  node;
    logic [hufd_pkg::CHILD_W-1:0] zc;
    logic [hufd_pkg::CHILD_W-1:0] oc;
    logic [7:0]                   src;
    logic [hufd_pkg::LEN_W-1:0]   len;
    bit                           typed;
    logic [hufd_pkg::SYM_W-1:0]   exp_sym;
    logic                         exp_last;
  } stim_row_t;

  localparam int DIR_ROWS = 25;

  // typed rows hold results that follow directly from the tree and the length
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_NODE, 8'd254, 9'h000, 9'h0FF, 8'h00, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h00, 24'd0, 1'b1, 8'h00, 1'b1},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'hFF, 24'd0, 1'b1, 8'hFF, 1'b1},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'hFE, 24'd0, 1'b1, 8'h00, 1'b1},
    '{ROW_NODE, 8'd255, 9'h1FE, 9'h1FE, 8'h00, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h01, 24'd0, 1'b1, 8'hFF, 1'b1},
    '{ROW_NODE, 8'd0,   9'h055, 9'h0AA, 8'h00, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_NODE, 8'd254, 9'h100, 9'h1FE, 8'h00, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h00, 24'd0, 1'b1, 8'h55, 1'b1},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h02, 24'd0, 1'b1, 8'hAA, 1'b1},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'hFF, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h7F, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h01, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_LEN,  8'd0,   9'h000, 9'h000, 8'h00, 24'd8, 1'b0, 8'h00, 1'b0},
    '{ROW_NODE, 8'd254, 9'h000, 9'h0FF, 8'h00, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'hA5, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_LEN,  8'd0,   9'h000, 9'h000, 8'h00, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h5A, 24'd0, 1'b1, 8'h00, 1'b1},
    '{ROW_LEN,  8'd0,   9'h000, 9'h000, 8'h00, LEN_MAX, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h3C, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_LEN,  8'd0,   9'h000, 9'h000, 8'h00, 24'd3, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'hC3, 24'd0, 1'b1, 8'hFF, 1'b1},
    '{ROW_NODE, 8'd1,   9'h1FE, 9'h101, 8'h00, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_NODE, 8'd254, 9'h1FF, 9'h0FF, 8'h00, 24'd0, 1'b0, 8'h00, 1'b0},
    '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 8'h02, 24'd0, 1'b0, 8'h00, 1'b0}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [hufd_pkg::IN_DATA_W-1:0] in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [hufd_pkg::SYM_W-1:0]     out_tdata;
  logic                           out_tlast;
  logic                           cfg_wr_en;
  logic [hufd_pkg::LEN_W-1:0]     cfg_wr_data;

  // decoder state as seen by the predictor
  hufd_pkg::node_t             node_table [hufd_pkg::NODE_COUNT_DEF];
  logic [hufd_pkg::NODE_W-1:0] walk_node;
  logic [hufd_pkg::LEN_W-1:0]  sym_count;
  logic [hufd_pkg::LEN_W-1:0]  chunk_len;
  logic [hufd_pkg::NODE_W-1:0] written_nodes [$];

  sym_result_t pending_symbols [$];
  int          mismatch_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_seq = 0;

  always #1 clk = ~clk;

  huffman_tree_byte_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void load_node(input logic [hufd_pkg::NODE_W-1:0] idx,
                                    input logic [hufd_pkg::CHILD_W-1:0] zc,
                                    input logic [hufd_pkg::CHILD_W-1:0] oc);
    if (idx < hufd_pkg::NODE_COUNT_DEF) begin
      node_table[idx].zero_child = zc;
      node_table[idx].one_child = oc;
      written_nodes.push_back(idx);
    end
  endfunction

  // walks one source byte, lowest bit first, and queues the symbols it yields
  function automatic void predict_decode(input logic [7:0] src,
                                         inout sym_result_t found [$]);
    logic [hufd_pkg::CHILD_W-1:0] child;
    logic [hufd_pkg::LEN_W-1:0]   next_count;
    sym_result_t                  res;
    for (int b = 0; b < hufd_pkg::BYTE_BITS; b++) begin
      // a node past the table reads as two zero leaves
      if (walk_node < hufd_pkg::NODE_COUNT_DEF)
        child = src[b] ? node_table[walk_node].one_child : node_table[walk_node].zero_child;
      else
        child = '0;
      if (child < LEAF_LIMIT) begin
        next_count = sym_count + 1'b1;
        res.symbol = child[hufd_pkg::SYM_W-1:0];
        res.chunk_last = (next_count == '0) || (next_count >= chunk_len);
        found.push_back(res);
        walk_node = HEAD_NODE;
        if (res.chunk_last) begin
          sym_count = '0;
          break;
        end
        sym_count = next_count;
      end else begin
        walk_node = child[hufd_pkg::NODE_W-1:0];
      end
    end
  endfunction

  // a leaf, or a pointer to a node already written so no walk reaches an empty entry
  function automatic logic [hufd_pkg::CHILD_W-1:0] pick_child(input int leaf_pct);
    int                          depth;
    logic [hufd_pkg::NODE_W-1:0] target;
    if ($urandom_range(99) < leaf_pct) return hufd_pkg::CHILD_W'($urandom_range(255));
    depth = written_nodes.size();
    if ($urandom_range(99) < 70)
      target = written_nodes[depth - 1 - $urandom_range(depth > 4 ? 4 : depth - 1)];
    else
      target = written_nodes[$urandom_range(depth - 1)];
    return {1'b1, target};
  endfunction

  task automatic send_item(input logic cmd, input logic [hufd_pkg::NODE_W-1:0] idx,
                           input logic [hufd_pkg::CHILD_W-1:0] zc,
                           input logic [hufd_pkg::CHILD_W-1:0] oc,
                           input logic [7:0] src, input bit typed,
                           input logic [hufd_pkg::SYM_W-1:0] exp_sym,
                           input logic exp_last);
    sym_result_t found [$];
    sym_result_t res;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {6'd0, src, oc, zc, idx};
    do @(posedge clk); while (!in_tready);
    if (cmd == hufd_pkg::CMD_WRITE_NODE) begin
      load_node(idx, zc, oc);
    end else begin
      predict_decode(src, found);
      if (typed) begin
        res.symbol = exp_sym;
        res.chunk_last = exp_last;
        pending_symbols.push_back(res);
      end else begin
        foreach (found[i]) pending_symbols.push_back(found[i]);
      end
    end
  endtask

  task automatic send_node(input logic [hufd_pkg::NODE_W-1:0] idx,
                           input logic [hufd_pkg::CHILD_W-1:0] zc,
                           input logic [hufd_pkg::CHILD_W-1:0] oc);
    send_item(hufd_pkg::CMD_WRITE_NODE, idx, zc, oc, 8'($urandom_range(255)), 1'b0, '0,
              1'b0);
  endtask

  task automatic send_byte(input logic [7:0] src);
    send_item(hufd_pkg::CMD_DECODE_BYTE, hufd_pkg::NODE_W'($urandom_range(255)),
              hufd_pkg::CHILD_W'($urandom_range(511)),
              hufd_pkg::CHILD_W'($urandom_range(511)), src, 1'b0, '0, 1'b0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_chunk_len(input logic [hufd_pkg::LEN_W-1:0] len);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chunk_len = len;
  endtask

  // receiver: random stalls plus an occasional long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : symbol_check
    sym_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_symbols.size() == 0) begin
        note_failure($sformatf("unexpected symbol %02h last %0b", out_tdata, out_tlast));
      end else begin
        want = pending_symbols.pop_front();
        if (want.symbol !== out_tdata || want.chunk_last !== out_tlast)
          note_failure($sformatf("symbol exp %02h last %0b, got %02h last %0b",
                                 want.symbol, want.chunk_last, out_tdata, out_tlast));
      end
    end
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int                          phase;
    int                          n;
    int                          pick;
    logic [hufd_pkg::LEN_W-1:0]  len;
    logic [hufd_pkg::NODE_W-1:0] idx;
    stim_row_t                   row;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = hufd_pkg::CMD_WRITE_NODE;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    walk_node = HEAD_NODE;
    sym_count = '0;
    chunk_len = 24'd1;
    tx_idle_pct = 15;
    rx_idle_pct = 47;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_NODE: begin
          send_item(hufd_pkg::CMD_WRITE_NODE, row.node, row.zc, row.oc, row.src, 1'b0, '0,
                    1'b0);
        end
        ROW_BYTE: begin
          send_item(hufd_pkg::CMD_DECODE_BYTE, row.node, row.zc, row.oc, row.src, row.typed,
                    row.exp_sym, row.exp_last);
        end
        default: begin
          write_chunk_len(row.len);
        end
      endcase
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      tx_idle_pct = (phase < 2) ? 15 : ((phase < 4) ? 47 : 0);
      rx_idle_pct = (phase < 2) ? 47 : ((phase < 4) ? 15 : 0);
      case (phase)
        0: len = 24'd2;
        1: len = 24'd1;
        2: len = LEN_MAX;
        3: len = 24'd5;
        4: len = hufd_pkg::LEN_W'($urandom_range(1, 12));
        default: len = 24'd3;
      endcase
      write_chunk_len(len);

      // fresh subtree under the head node
      repeat ($urandom_range(2, 10))
        send_node(hufd_pkg::NODE_W'($urandom_range(253)), pick_child(40), pick_child(40));
      send_node(HEAD_NODE, pick_child(15), pick_child(15));

      n = 0;
      while (n < PHASE_ITEMS) begin
        if (phase == 1 && n == 15) hold_seq++;
        if (phase == 3 && n == 30) wait_drained();
        pick = $urandom_range(99);
        if (pick < 80) begin
          send_byte(8'($urandom_range(255)));
          n++;
        end else if (pick < 95) begin
          if ($urandom_range(1))
            idx = written_nodes[$urandom_range(written_nodes.size() - 1)];
          else
            idx = hufd_pkg::NODE_W'($urandom_range(254));
          send_node(idx, pick_child(45), pick_child(45));
          n++;
        end else begin
          // dropped by the block, not counted
          send_node(NO_NODE, hufd_pkg::CHILD_W'($urandom_range(511)),
                    hufd_pkg::CHILD_W'($urandom_range(511)));
        end
      end
    end

    wait_drained();
    if (pending_symbols.size() != 0) begin
      $display("%0d expected symbols never arrived", pending_symbols.size());
      mismatch_count += pending_symbols.size();
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
